// ===== hw/rtl/hsv2rgb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the HSV to RGB colour wheel.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Full channel level, also the divisor of every scaling step.
  localparam logic [7:0] FULL_LEVEL = 8'd255;
  // Reciprocal of three as 171/512, exact for floor division of any 7-bit value.
  localparam logic [7:0] RECIP3       = 8'd171;
  localparam int unsigned RECIP3_SHIFT = 9;
  // Number of register stages between the input and the output word.
  localparam logic [2:0] PIPE_DEPTH = 3'd5;

  // Sixths of the wheel, named after the two primaries or secondaries they join.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW     = 3'd0,
    SEC_YELLOW_GREEN   = 3'd1,
    SEC_GREEN_CYAN     = 3'd2,
    SEC_CYAN_BLUE      = 3'd3,
    SEC_BLUE_MAGENTA   = 3'd4,
    SEC_MAGENTA_RED    = 3'd5
  } sector_e;

  // Word passed from the front end to the ramp stages.
  typedef struct packed {
    sector_e    sector;
    logic [7:0] step;
    logic [7:0] val;
    logic [7:0] lvl_floor;
  } lvl_t;

  // Word passed from the ramp stages to the channel router.
  typedef struct packed {
    sector_e    sector;
    logic [7:0] val;
    logic [7:0] lvl_floor;
    logic [7:0] span;
  } ramp_t;

  // Final colour word.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Remainder of a 7-bit value by three, via the reciprocal.
  function automatic logic [1:0] mod3_7(input logic [6:0] x);
    logic [14:0] m;
    logic [5:0]  q;
    logic [6:0]  r;
    m = 15'(x) * 15'(RECIP3);
    q = m[14:RECIP3_SHIFT];
    r = x - 7'(q) * 7'd3;
    return r[1:0];
  endfunction

  // Truncating division by 255 of a product of two bytes. The estimate is at most
  // one short, so one compare against the remainder completes it.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] est;
    logic [8:0]  q;
    logic [17:0] rem;
    est = 17'(x) + 17'(x[15:8]);
    q   = est[16:8];
    rem = 18'(x) + 18'(q) - 18'({q, 8'b0});
    if (rem >= 18'(FULL_LEVEL)) begin
      q = q + 9'd1;
    end
    return q[7:0];
  endfunction

endpackage

// ===== hw/rtl/hsv2rgb_if.sv =====
// Handshake interfaces for the HSV input channel and the RGB output channel.
`timescale 1ns / 1ps

interface hsv_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface rgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hw/rtl/hsv2rgb_front.sv =====
// Front end: hue reduction, floor product and floor division, two stages.
`timescale 1ns / 1ps

module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] hue_i,
  input  logic [7:0]  sat_i,
  input  logic [7:0]  val_i,
  output logic        valid_o,
  input  logic        ready_i,
  output lvl_t        data_o
);

  typedef struct packed {
    sector_e     sector;
    logic [7:0]  step;
    logic [7:0]  val;
    logic [15:0] prod;
  } front_a_t;

  front_a_t   a_d, a_q;
  lvl_t       b_d, b_q;
  logic       a_valid_q, b_valid_q;
  logic       a_ready, b_ready;
  logic [10:0] hue_red;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;

  // 1536 is three times 512, so only the bits above bit 8 need reducing.
  always_comb begin
    hue_red   = {mod3_7(hue_i[15:9]), hue_i[8:0]};
    a_d.sector = sector_e'(hue_red[10:8]);
    a_d.step   = hue_red[7:0];
    a_d.val    = val_i;
    a_d.prod   = 16'(val_i) * 16'(FULL_LEVEL - sat_i);
  end

  always_comb begin
    b_d.sector    = a_q.sector;
    b_d.step      = a_q.step;
    b_d.val       = a_q.val;
    b_d.lvl_floor = div255(a_q.prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && a_ready) begin
      a_q <= a_d;
    end
    if (a_valid_q && b_ready) begin
      b_q <= b_d;
    end
  end

  assign ready_o = a_ready;
  assign valid_o = b_valid_q;
  assign data_o  = b_q;

endmodule

// ===== hw/rtl/hsv2rgb_ramp.sv =====
// Ramp stages: span product and span division, two stages.
`timescale 1ns / 1ps

module hsv2rgb_ramp import hsv2rgb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  lvl_t  data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output ramp_t data_o
);

  typedef struct packed {
    sector_e     sector;
    logic [7:0]  val;
    logic [7:0]  lvl_floor;
    logic [15:0] prod;
  } ramp_c_t;

  ramp_c_t    c_d, c_q;
  ramp_t      d_d, d_q;
  logic       c_valid_q, d_valid_q;
  logic       c_ready, d_ready;
  logic [7:0] diff;

  assign d_ready = !d_valid_q || ready_i;
  assign c_ready = !c_valid_q || d_ready;

  // The floor never exceeds the value, so the difference needs no sign bit.
  always_comb begin
    diff          = data_i.val - data_i.lvl_floor;
    c_d.sector    = data_i.sector;
    c_d.val       = data_i.val;
    c_d.lvl_floor = data_i.lvl_floor;
    c_d.prod      = 16'(diff) * 16'(data_i.step);
  end

  always_comb begin
    d_d.sector    = c_q.sector;
    d_d.val       = c_q.val;
    d_d.lvl_floor = c_q.lvl_floor;
    d_d.span      = div255(c_q.prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && c_ready) begin
      c_q <= c_d;
    end
    if (c_valid_q && d_ready) begin
      d_q <= d_d;
    end
  end

  assign ready_o = c_ready;
  assign valid_o = d_valid_q;
  assign data_o  = d_q;

endmodule

// ===== hw/rtl/hsv2rgb_route.sv =====
// Channel router: builds both ramps and steers levels to red, green and blue.
`timescale 1ns / 1ps

module hsv2rgb_route import hsv2rgb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  ramp_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output rgb_t  data_o
);

  rgb_t       e_d, e_q;
  logic       e_valid_q;
  logic       e_ready;
  logic [7:0] up, dn, v, p;

  assign e_ready = !e_valid_q || ready_i;

  // Both ramps stay between floor and value, so eight bits always suffice.
  always_comb begin
    v  = data_i.val;
    p  = data_i.lvl_floor;
    up = p + data_i.span;
    dn = v - data_i.span;
    case (data_i.sector)
      SEC_RED_YELLOW: begin
        e_d = '{red: v, green: up, blue: p};
      end
      SEC_YELLOW_GREEN: begin
        e_d = '{red: dn, green: v, blue: p};
      end
      SEC_GREEN_CYAN: begin
        e_d = '{red: p, green: v, blue: up};
      end
      SEC_CYAN_BLUE: begin
        e_d = '{red: p, green: dn, blue: v};
      end
      SEC_BLUE_MAGENTA: begin
        e_d = '{red: up, green: p, blue: v};
      end
      default: begin
        e_d = '{red: v, green: p, blue: dn};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (e_ready) begin
      e_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && e_ready) begin
      e_q <= e_d;
    end
  end

  assign ready_o = e_ready;
  assign valid_o = e_valid_q;
  assign data_o  = e_q;

endmodule

// ===== hw/rtl/hsv_to_rgb_wheel.sv =====
// Top level of the HSV to RGB colour wheel converter.
// Throughput: one word per cycle while the output accepts; five register stages,
// each stage holds while the next is full, so a stall at the output backs up
// without losing or repeating words.
// Reset clears the stage valid bits and the in-flight count of the checks; the converter keeps no other state.
`timescale 1ns / 1ps

module hsv_to_rgb_wheel import hsv2rgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsv_in_if.sink     hsv_i,
  rgb_out_if.source  rgb_o
);

  logic  mid_valid, mid_ready;
  lvl_t  mid_data;
  logic  rmp_valid, rmp_ready;
  ramp_t rmp_data;
  rgb_t  out_data;

  hsv2rgb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hsv_i.valid),
    .ready_o (hsv_i.ready),
    .hue_i   (hsv_i.hue),
    .sat_i   (hsv_i.saturation),
    .val_i   (hsv_i.brightness),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .data_o  (mid_data)
  );

  hsv2rgb_ramp u_ramp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (mid_data),
    .valid_o (rmp_valid),
    .ready_i (rmp_ready),
    .data_o  (rmp_data)
  );

  hsv2rgb_route u_route (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rmp_valid),
    .ready_o (rmp_ready),
    .data_i  (rmp_data),
    .valid_o (rgb_o.valid),
    .ready_i (rgb_o.ready),
    .data_o  (out_data)
  );

  assign rgb_o.red   = out_data.red;
  assign rgb_o.green = out_data.green;
  assign rgb_o.blue  = out_data.blue;

  // Count of words inside the pipeline, kept for the checks below.
  logic [2:0] in_flight_d, in_flight_q;
  logic       word_in, word_out;

  assign word_in     = hsv_i.valid && hsv_i.ready;
  assign word_out    = rgb_o.valid && rgb_o.ready;
  assign in_flight_d = in_flight_q + 3'(word_in) - 3'(word_out);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_flight_q <= 3'd0;
    end else begin
      in_flight_q <= in_flight_d;
    end
  end

  a_no_phantom_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_o.valid |-> in_flight_q != 3'd0)
    else $error("output word shown with no word inside the pipeline");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight_q <= PIPE_DEPTH)
    else $error("more words inside the pipeline than it has stages");

  a_floor_below_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid |-> mid_data.lvl_floor <= mid_data.val)
    else $error("floor level above brightness");

  a_span_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rmp_valid |-> rmp_data.span <= (rmp_data.val - rmp_data.lvl_floor))
    else $error("ramp span exceeds the gap between floor and brightness");

endmodule
